>>> hdl/lds_pkg.sv
// Shared constants and codes for the diffuse shading pipeline.
// No dependencies; used by every other file through scoped names.
package lds_pkg;

    localparam int COLOR_W   = 9;
    localparam int PIX_W     = 8;
    localparam int NUM_CH    = 3;
    localparam int CH_W      = NUM_CH * COLOR_W;
    // Side band: {zero, negative, ambient[3], diffuse[3]}, red in the low slot.
    localparam int SIDE_W    = 2 + 2 * CH_W;
    localparam int SIDE_ZERO = SIDE_W - 1;
    localparam int SIDE_NEG  = SIDE_W - 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_X = 2'd0,
        REG_LIGHT_Y = 2'd1,
        REG_LIGHT_Z = 2'd2
    } t_cfg_reg;

endpackage

>>> hdl/lambert_diffuse_shading.sv
// Top level of the Lambertian diffuse shading pipeline: light registers,
// front end, cosine cell chain and channel shaders. Uses lds_pkg and all hdl modules.
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+----------------------------
//  request   | i_hit_*, i_end_*, i_amb_*, i_dif_*        | taken when start && !busy
//  result    | o_pix_red, o_pix_green, o_pix_blue        | o_valid strobe, one cycle
//  config    | i_cfg_idx, i_cfg_data                     | written when i_cfg_we
//
// One request per cycle; busy stays low. The pipeline has five front
// stages, one cell per cosine bit and one shade stage. Reset (synchronous,
// active low) drops all requests in flight and clears the light position
// to the origin. The result strobe cannot be held off: each result appears
// for exactly one cycle.
module lambert_diffuse_shading #(
    parameter int COORD_WIDTH   = 24,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [COORD_WIDTH-1:0]          i_hit_x,
    input  logic [COORD_WIDTH-1:0]          i_hit_y,
    input  logic [COORD_WIDTH-1:0]          i_hit_z,
    input  logic [COORD_WIDTH-1:0]          i_end_x,
    input  logic [COORD_WIDTH-1:0]          i_end_y,
    input  logic [COORD_WIDTH-1:0]          i_end_z,
    input  logic [lds_pkg::COLOR_W-1:0]     i_amb_red,
    input  logic [lds_pkg::COLOR_W-1:0]     i_amb_green,
    input  logic [lds_pkg::COLOR_W-1:0]     i_amb_blue,
    input  logic [lds_pkg::COLOR_W-1:0]     i_dif_red,
    input  logic [lds_pkg::COLOR_W-1:0]     i_dif_green,
    input  logic [lds_pkg::COLOR_W-1:0]     i_dif_blue,
    input  logic                            i_cfg_we,
    input  logic [lds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]          i_cfg_data,
    output logic                            o_valid,
    output logic [lds_pkg::PIX_W-1:0]       o_pix_red,
    output logic [lds_pkg::PIX_W-1:0]       o_pix_green,
    output logic [lds_pkg::PIX_W-1:0]       o_pix_blue
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = COS_FRAC_BITS;
    localparam int PW = 4 * (CW + 1) + 4;
    localparam int RW = PW + 2 * FB + 3;
    localparam int BW = PW + FB + 1;
    localparam int NC = FB + 1;

    logic [CW-1:0] r_light_x, r_light_y, r_light_z;
    logic          r_out_valid;

    logic                       w_v    [NC+1];
    logic [RW-1:0]              w_r    [NC+1];
    logic [BW-1:0]              w_b    [NC+1];
    logic [PW-1:0]              w_p    [NC+1];
    logic [FB:0]                w_c    [NC+1];
    logic [lds_pkg::SIDE_W-1:0] w_side [NC+1];

    logic signed [FB+1:0]        n_cos;
    logic [lds_pkg::PIX_W-1:0]   w_pix [lds_pkg::NUM_CH];

    // The pipeline never stalls, so a request is always taken.
    assign busy = 1'b0;

    // Light position registers; an index past light_z is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
        end else if (i_cfg_we) begin
            case (lds_pkg::t_cfg_reg'(i_cfg_idx))
                lds_pkg::REG_LIGHT_X: r_light_x <= i_cfg_data;
                lds_pkg::REG_LIGHT_Y: r_light_y <= i_cfg_data;
                lds_pkg::REG_LIGHT_Z: r_light_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: vectors, lengths, dot product, wide products.
    lds_vec #(
        .CW (CW),
        .FB (FB),
        .PW (PW),
        .RW (RW)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_hit   ({i_hit_z, i_hit_y, i_hit_x}),
        .i_end   ({i_end_z, i_end_y, i_end_x}),
        .i_light ({r_light_z, r_light_y, r_light_x}),
        .i_amb   ({i_amb_blue, i_amb_green, i_amb_red}),
        .i_dif   ({i_dif_blue, i_dif_green, i_dif_red}),
        .o_valid (w_v[0]),
        .o_p     (w_p[0]),
        .o_r     (w_r[0]),
        .o_side  (w_side[0])
    );

    // Start the root search with c = 0 and c*P = 0.
    assign w_b[0] = '0;
    assign w_c[0] = '0;

    // Chain of cells, most significant cosine bit first.
    for (genvar k = 0; k < NC; k++) begin : g_cell
        lds_root_cell #(
            .PW  (PW),
            .RW  (RW),
            .FB  (FB),
            .BIT (FB - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_r     (w_r[k]),
            .i_b     (w_b[k]),
            .i_p     (w_p[k]),
            .i_c     (w_c[k]),
            .i_side  (w_side[k]),
            .o_valid (w_v[k+1]),
            .o_r     (w_r[k+1]),
            .o_b     (w_b[k+1]),
            .o_p     (w_p[k+1]),
            .o_c     (w_c[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // Apply the dot product sign; a zero-length vector forces cosine 0.
    always_comb begin
        if (w_side[NC][lds_pkg::SIDE_ZERO]) begin
            n_cos = '0;
        end else if (w_side[NC][lds_pkg::SIDE_NEG]) begin
            n_cos = -$signed({1'b0, w_c[NC]});
        end else begin
            n_cos = $signed({1'b0, w_c[NC]});
        end
    end

    for (genvar k = 0; k < lds_pkg::NUM_CH; k++) begin : g_ch
        lds_shade #(
            .FB (FB)
        ) u_shade (
            .i_clk (i_clk),
            .i_cos (n_cos),
            .i_amb (w_side[NC][lds_pkg::CH_W + k*lds_pkg::COLOR_W +: lds_pkg::COLOR_W]),
            .i_dif (w_side[NC][k*lds_pkg::COLOR_W +: lds_pkg::COLOR_W]),
            .o_pix (w_pix[k])
        );
    end

    // Align the result strobe with the shade registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_v[NC];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pix_red   = w_pix[0];
    assign o_pix_green = w_pix[1];
    assign o_pix_blue  = w_pix[2];

endmodule

>>> hdl/lds_vec.sv
// Front end: normal and light vectors, squared lengths, dot product and the
// wide products |N|^2*|L|^2 and dot^2, split into partial products. Uses lds_pkg.
module lds_vec #(
    parameter int CW = 24,
    parameter int FB = 15,
    parameter int PW = 4 * (CW + 1) + 4,
    parameter int RW = PW + 2 * FB + 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [2:0][CW-1:0]         i_hit,
    input  logic [2:0][CW-1:0]         i_end,
    input  logic [2:0][CW-1:0]         i_light,
    input  logic [lds_pkg::CH_W-1:0]   i_amb,
    input  logic [lds_pkg::CH_W-1:0]   i_dif,
    output logic                       o_valid,
    output logic [PW-1:0]              o_p,
    output logic [RW-1:0]              o_r,
    output logic [lds_pkg::SIDE_W-1:0] o_side
);

    localparam int VW  = CW + 1;
    localparam int MW  = 2 * VW;
    localparam int SW  = MW + 2;
    localparam int DW  = MW;
    localparam int H   = (SW + 1) / 2;
    localparam int HD  = (DW + 1) / 2;
    localparam int D2W = 2 * DW;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [VW-1:0] r_n [3];
    logic signed [VW-1:0] r_l [3];
    logic signed [MW-1:0] r_nn [3];
    logic signed [MW-1:0] r_ll [3];
    logic signed [MW-1:0] r_nl [3];
    logic [2*lds_pkg::CH_W-1:0] r_col1, r_col2;

    logic [SW-1:0]            r_n2, r_l2;
    logic [DW-1:0]            r_dm;
    logic [lds_pkg::SIDE_W-1:0] r_side3, r_side4, r_side5;

    logic [2*(SW-H)-1:0]  r_pp_hh;
    logic [SW-1:0]        r_pp_hl, r_pp_lh;
    logic [2*H-1:0]       r_pp_ll;
    logic [2*(DW-HD)-1:0] r_dd_hh;
    logic [DW-1:0]        r_dd_hl;
    logic [2*HD-1:0]      r_dd_ll;

    logic [PW-1:0] r_p;
    logic [RW-1:0] r_r;

    logic [SW-1:0]          n_n2, n_l2;
    logic signed [DW+1:0]   n_dot;
    logic [DW+1:0]          n_dabs;
    logic                   n_neg, n_zero;
    logic [PW-1:0]          n_p;
    logic [D2W-1:0]         n_d2;

    always_comb begin
        n_n2   = SW'($unsigned(r_nn[0])) + SW'($unsigned(r_nn[1]))
               + SW'($unsigned(r_nn[2]));
        n_l2   = SW'($unsigned(r_ll[0])) + SW'($unsigned(r_ll[1]))
               + SW'($unsigned(r_ll[2]));
        n_dot  = (DW+2)'(r_nl[0]) + (DW+2)'(r_nl[1]) + (DW+2)'(r_nl[2]);
        n_neg  = n_dot[DW+1];
        n_dabs = n_neg ? $unsigned(-n_dot) : $unsigned(n_dot);
        n_zero = (n_n2 == '0) || (n_l2 == '0);
        n_p    = (PW'(r_pp_hh) << (2 * H)) + (PW'(r_pp_hl) << H)
               + (PW'(r_pp_lh) << H) + PW'(r_pp_ll);
        n_d2   = (D2W'(r_dd_hh) << (2 * HD)) + (D2W'(r_dd_hl) << (HD + 1))
               + D2W'(r_dd_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_n[k]  <= $signed({i_hit[k][CW-1], i_hit[k]})
                     - $signed({i_end[k][CW-1], i_end[k]});
            r_l[k]  <= $signed({i_light[k][CW-1], i_light[k]})
                     - $signed({i_hit[k][CW-1], i_hit[k]});
            r_nn[k] <= r_n[k] * r_n[k];
            r_ll[k] <= r_l[k] * r_l[k];
            r_nl[k] <= r_n[k] * r_l[k];
        end
        r_col1  <= {i_amb, i_dif};
        r_col2  <= r_col1;
        // stage 3: reduce to lengths and dot magnitude
        r_n2    <= n_n2;
        r_l2    <= n_l2;
        r_dm    <= n_dabs[DW-1:0];
        r_side3 <= {n_zero, n_neg, r_col2};
        // stage 4: half-width partial products
        r_pp_hh <= r_n2[SW-1:H] * r_l2[SW-1:H];
        r_pp_hl <= r_n2[SW-1:H] * r_l2[H-1:0];
        r_pp_lh <= r_n2[H-1:0] * r_l2[SW-1:H];
        r_pp_ll <= r_n2[H-1:0] * r_l2[H-1:0];
        r_dd_hh <= r_dm[DW-1:HD] * r_dm[DW-1:HD];
        r_dd_hl <= r_dm[DW-1:HD] * r_dm[HD-1:0];
        r_dd_ll <= r_dm[HD-1:0] * r_dm[HD-1:0];
        r_side4 <= r_side3;
        // stage 5: combine partials, scale dot^2 by 2^(2*FB)
        r_p     <= n_p;
        r_r     <= RW'(n_d2) << (2 * FB);
        r_side5 <= r_side4;
    end

    assign o_valid = r_v5;
    assign o_p     = r_p;
    assign o_r     = r_r;
    assign o_side  = r_side5;

endmodule

>>> hdl/lds_root_cell.sv
// One cell of the cosine chain: settles one bit of the quotient-root
// c = floor(2^FB * |dot| / sqrt(P)) by add, compare and subtract. Uses lds_pkg.
module lds_root_cell #(
    parameter int PW  = 104,
    parameter int RW  = 137,
    parameter int FB  = 15,
    parameter int BIT = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [RW-1:0]              i_r,
    input  logic [PW+FB:0]             i_b,
    input  logic [PW-1:0]              i_p,
    input  logic [FB:0]                i_c,
    input  logic [lds_pkg::SIDE_W-1:0] i_side,
    output logic                       o_valid,
    output logic [RW-1:0]              o_r,
    output logic [PW+FB:0]             o_b,
    output logic [PW-1:0]              o_p,
    output logic [FB:0]                o_c,
    output logic [lds_pkg::SIDE_W-1:0] o_side
);

    localparam int BW = PW + FB + 1;

    logic                       r_valid;
    logic [RW-1:0]              r_r;
    logic [BW-1:0]              r_b;
    logic [PW-1:0]              r_p;
    logic [FB:0]                r_c;
    logic [lds_pkg::SIDE_W-1:0] r_side;

    logic [RW-1:0] n_x;
    logic          n_take;

    // (c + 2^BIT)^2 * P - c^2 * P = 2^(BIT+1) * cP + 2^(2*BIT) * P
    always_comb begin
        n_x    = (RW'(i_b) << (BIT + 1)) + (RW'(i_p) << (2 * BIT));
        n_take = (i_r >= n_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r    <= n_take ? (i_r - n_x) : i_r;
        r_b    <= n_take ? (i_b + (BW'(i_p) << BIT)) : i_b;
        r_c    <= i_c | ((FB+1)'(n_take) << BIT);
        r_p    <= i_p;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
    assign o_b     = r_b;
    assign o_p     = r_p;
    assign o_c     = r_c;
    assign o_side  = r_side;

endmodule

>>> hdl/lds_shade.sv
// One colour channel: ambient + diffuse * cosine, truncate, clamp to 0..255.
// Uses lds_pkg for colour and pixel widths.
module lds_shade #(
    parameter int FB = 15
) (
    input  logic                         i_clk,
    input  logic signed [FB+1:0]         i_cos,
    input  logic [lds_pkg::COLOR_W-1:0]  i_amb,
    input  logic [lds_pkg::COLOR_W-1:0]  i_dif,
    output logic [lds_pkg::PIX_W-1:0]    o_pix
);

    localparam int NW = lds_pkg::COLOR_W + FB + 3;
    localparam int QW = NW - FB;

    logic signed [NW-1:0]        n_num;
    logic [QW-1:0]               n_q;
    logic [lds_pkg::PIX_W-1:0]   n_pix;
    logic [lds_pkg::PIX_W-1:0]   r_pix;

    always_comb begin
        n_num = $signed(NW'({i_amb, {FB{1'b0}}}))
              + NW'($signed({1'b0, i_dif}) * i_cos);
        n_q   = n_num[NW-1:FB];
        // the sum is truncated toward minus infinity; a negative sum clamps to 0
        if (n_num[NW-1]) begin
            n_pix = '0;
        end else if (n_q > QW'(lds_pkg::PIX_MAX)) begin
            n_pix = lds_pkg::PIX_MAX;
        end else begin
            n_pix = n_q[lds_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_pix = r_pix;

endmodule
